FILE: rtl/core/dspr_pkg.sv
package dspr_pkg;

	// Field widths
	localparam int PCT_W      = 8;
	localparam int DUTY_W     = 8;
	localparam int STEP_W     = 8;
	localparam int INTERVAL_W = 16;

	// Scaling constants
	localparam int SPEED_PERCENT_MAX = 100;
	localparam int PWM_MAX           = 255;
	localparam int PCT_CLAMP_W       = $clog2(SPEED_PERCENT_MAX + 1);

	// percent * PWM_MAX / SPEED_PERCENT_MAX as one multiply by a rounded-up reciprocal;
	// the shift keeps the error below one part in SPEED_PERCENT_MAX for every clamped percent
	localparam int DUTY_SHIFT = 16;
	localparam int DUTY_MUL   = (PWM_MAX * (2 ** DUTY_SHIFT) + SPEED_PERCENT_MAX - 1)
		/ SPEED_PERCENT_MAX;
	localparam int DUTY_MUL_W = $clog2(DUTY_MUL + 1);
	localparam int PROD_W     = PCT_CLAMP_W + DUTY_MUL_W;

	// Register file
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_RAMP_STEP     = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_RAMP_INTERVAL = 1'b1;
	localparam logic [STEP_W-1:0]     RAMP_STEP_RST     = 8'd5;
	localparam logic [INTERVAL_W-1:0] RAMP_INTERVAL_RST = 16'd20;

	typedef enum logic [1:0] {
		MODE_TICK      = 2'd0,
		MODE_SET_LEFT  = 2'd1,
		MODE_SET_RIGHT = 2'd2,
		MODE_STOP      = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_RAMP,
		OP_SET,
		OP_STOP
	} side_op_t;

	typedef struct packed {
		logic [STEP_W-1:0]     ramp_step;
		logic [INTERVAL_W-1:0] ramp_interval;
	} cfg_t;

endpackage

FILE: rtl/core/dspr_regs.sv
module dspr_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dspr_pkg::ADDR_W-1:0]   paddr,
	input  logic [dspr_pkg::DATA_W-1:0]   pwdata,
	output logic [dspr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output dspr_pkg::cfg_t                cfg
);

	logic [dspr_pkg::REG_IDX_W-1:0]  idx;
	logic                            wr_en;
	logic [dspr_pkg::STEP_W-1:0]     ramp_step_q;
	logic [dspr_pkg::INTERVAL_W-1:0] ramp_interval_q;

	assign idx    = paddr[dspr_pkg::ADDR_W-1 -: dspr_pkg::REG_IDX_W];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_step_q     <= dspr_pkg::RAMP_STEP_RST;
			ramp_interval_q <= dspr_pkg::RAMP_INTERVAL_RST;
		end else if (wr_en) begin
			unique case (idx)
				dspr_pkg::REG_RAMP_STEP: begin
					ramp_step_q <= pwdata[dspr_pkg::STEP_W-1:0];
				end
				dspr_pkg::REG_RAMP_INTERVAL: begin
					ramp_interval_q <= pwdata[dspr_pkg::INTERVAL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			dspr_pkg::REG_RAMP_STEP: begin
				prdata = dspr_pkg::DATA_W'(ramp_step_q);
			end
			dspr_pkg::REG_RAMP_INTERVAL: begin
				prdata = dspr_pkg::DATA_W'(ramp_interval_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign cfg.ramp_step     = ramp_step_q;
	assign cfg.ramp_interval = ramp_interval_q;

endmodule

FILE: rtl/core/dspr_tick.sv
module dspr_tick (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            tick_en,
	input  logic [dspr_pkg::INTERVAL_W-1:0] ramp_interval,
	output logic                            fire
);

	logic [dspr_pkg::INTERVAL_W-1:0] count_q;
	logic [dspr_pkg::INTERVAL_W-1:0] count_inc;

	// saturate at all ones
	assign count_inc = (count_q != '1) ? count_q + 1'b1 : count_q;
	assign fire      = tick_en && (count_inc >= ramp_interval);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (tick_en) begin
			count_q <= fire ? '0 : count_inc;
		end
	end

endmodule

FILE: rtl/core/dspr_side.sv
module dspr_side (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dspr_pkg::side_op_t          op,
	input  logic [dspr_pkg::DUTY_W-1:0] goal_in,
	input  logic                        fwd_in,
	input  logic [dspr_pkg::STEP_W-1:0] ramp_step,
	output logic [dspr_pkg::DUTY_W-1:0] duty,
	output logic [dspr_pkg::DUTY_W-1:0] duty_next,
	output logic                        dir_fwd
);

	logic [dspr_pkg::DUTY_W-1:0] duty_q;
	logic [dspr_pkg::DUTY_W-1:0] goal_q;
	logic                        wanted_q;
	logic                        driven_q;

	logic [dspr_pkg::DUTY_W-1:0] goal_next;
	logic                        wanted_next;
	logic                        driven_next;
	logic [dspr_pkg::DUTY_W:0]   up_sum;
	logic [dspr_pkg::DUTY_W-1:0] down_val;
	logic [dspr_pkg::DUTY_W-1:0] ramp_val;

	// one slew step toward the goal, never past it
	always_comb begin
		up_sum   = {1'b0, duty_q} + {1'b0, ramp_step};
		down_val = (duty_q >= ramp_step) ? duty_q - ramp_step : '0;
		ramp_val = duty_q;
		if (duty_q < goal_q) begin
			ramp_val = (up_sum > {1'b0, goal_q}) ? goal_q : up_sum[dspr_pkg::DUTY_W-1:0];
		end else if (duty_q > goal_q) begin
			ramp_val = (down_val < goal_q) ? goal_q : down_val;
		end
	end

	always_comb begin
		duty_next   = duty_q;
		goal_next   = goal_q;
		wanted_next = wanted_q;
		driven_next = driven_q;
		unique case (op)
			dspr_pkg::OP_HOLD: begin
			end
			dspr_pkg::OP_RAMP: begin
				duty_next   = ramp_val;
				driven_next = wanted_q;
			end
			dspr_pkg::OP_SET: begin
				// drop duty at once on reversal under way
				if ((fwd_in != wanted_q) && (duty_q != '0)) begin
					duty_next = '0;
				end
				wanted_next = fwd_in;
				goal_next   = goal_in;
			end
			dspr_pkg::OP_STOP: begin
				duty_next   = '0;
				goal_next   = '0;
				driven_next = wanted_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q   <= '0;
			goal_q   <= '0;
			wanted_q <= 1'b1;
			driven_q <= 1'b1;
		end else begin
			duty_q   <= duty_next;
			goal_q   <= goal_next;
			wanted_q <= wanted_next;
			driven_q <= driven_next;
		end
	end

	assign duty    = duty_q;
	assign dir_fwd = driven_q;

endmodule

FILE: rtl/core/dual_side_pwm_ramp_driver.sv
// Dual-side PWM ramp driver: left and right sides each carry one duty and one
// direction, shared by their front and rear motors. A request is a millisecond
// tick, a set command for one side (percent clamped to 0..100 and scaled to
// 0..255), or stop for both sides. Every request yields exactly one result: the
// duty and pin direction of both sides plus a moving flag, taken after the
// request's update. Throughput is one request per clock while out_ready holds; the
// input register takes the request at the accepting edge, then the state
// registers, which are the result, take its update once the result slot is free
// or being taken; out_valid rises at the same edge. The input side keeps
// accepting while a result waits, up to one request held in the input
// register. Registers: ramp_step at byte 0 (8 bits, reset 5), ramp_interval at
// byte 4 (16 bits, reset 20); write them only while no request is in flight.
module dual_side_pwm_ramp_driver (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [dspr_pkg::ADDR_W-1:0]        paddr,
	input  logic [dspr_pkg::DATA_W-1:0]        pwdata,
	output logic [dspr_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	// request channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         mode,
	input  logic signed [dspr_pkg::PCT_W-1:0]  speed_percent,
	input  logic                               forward,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [dspr_pkg::DUTY_W-1:0]        left_duty,
	output logic                               left_dir_fwd,
	output logic [dspr_pkg::DUTY_W-1:0]        right_duty,
	output logic                               right_dir_fwd,
	output logic                               moving
);

	dspr_pkg::cfg_t cfg;

	// stage 1: decoded request
	logic                              valid_s1;
	dspr_pkg::mode_t                   mode_s1;
	logic [dspr_pkg::DUTY_W-1:0]       goal_s1;
	logic                              fwd_s1;

	logic                              out_valid_q;
	logic                              moving_q;
	logic                              adv;
	logic                              fire;
	logic                              tick_en;

	logic [dspr_pkg::PCT_CLAMP_W-1:0]  pct_clamp;
	logic [dspr_pkg::PROD_W-1:0]       duty_prod;
	logic [dspr_pkg::DUTY_W-1:0]       goal_in;

	dspr_pkg::side_op_t                op_left;
	dspr_pkg::side_op_t                op_right;
	logic [dspr_pkg::DUTY_W-1:0]       left_next;
	logic [dspr_pkg::DUTY_W-1:0]       right_next;

	dspr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Clamp the percent to 0..SPEED_PERCENT_MAX, then scale to duty with one
	// constant multiply and a shift.
	always_comb begin
		if (speed_percent < 0) begin
			pct_clamp = '0;
		end else if (speed_percent > $signed(dspr_pkg::PCT_W'(dspr_pkg::SPEED_PERCENT_MAX)))
		begin
			pct_clamp = dspr_pkg::PCT_CLAMP_W'(dspr_pkg::SPEED_PERCENT_MAX);
		end else begin
			pct_clamp = speed_percent[dspr_pkg::PCT_CLAMP_W-1:0];
		end
		duty_prod = dspr_pkg::PROD_W'(pct_clamp)
			* dspr_pkg::PROD_W'(dspr_pkg::DUTY_MUL);
		goal_in = duty_prod[dspr_pkg::DUTY_SHIFT +: dspr_pkg::DUTY_W];
	end

	// Advance stage 1 into the state when the result slot is free or being taken.
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload of stage 1 needs no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1 <= dspr_pkg::mode_t'(mode);
			goal_s1 <= goal_in;
			fwd_s1  <= forward;
		end
	end

	assign tick_en = adv && (mode_s1 == dspr_pkg::MODE_TICK);

	dspr_tick u_tick (
		.clk           (clk),
		.arst_n        (arst_n),
		.tick_en       (tick_en),
		.ramp_interval (cfg.ramp_interval),
		.fire          (fire)
	);

	// Route the request to each side as one operation.
	always_comb begin
		op_left  = dspr_pkg::OP_HOLD;
		op_right = dspr_pkg::OP_HOLD;
		if (adv) begin
			unique case (mode_s1)
				dspr_pkg::MODE_TICK: begin
					if (fire) begin
						op_left  = dspr_pkg::OP_RAMP;
						op_right = dspr_pkg::OP_RAMP;
					end
				end
				dspr_pkg::MODE_SET_LEFT: begin
					op_left = dspr_pkg::OP_SET;
				end
				dspr_pkg::MODE_SET_RIGHT: begin
					op_right = dspr_pkg::OP_SET;
				end
				dspr_pkg::MODE_STOP: begin
					op_left  = dspr_pkg::OP_STOP;
					op_right = dspr_pkg::OP_STOP;
				end
				default: begin
				end
			endcase
		end
	end

	// The side state registers double as the result register: they only change
	// when the previous result has been taken.
	dspr_side u_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op_left),
		.goal_in   (goal_s1),
		.fwd_in    (fwd_s1),
		.ramp_step (cfg.ramp_step),
		.duty      (left_duty),
		.duty_next (left_next),
		.dir_fwd   (left_dir_fwd)
	);

	dspr_side u_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op_right),
		.goal_in   (goal_s1),
		.fwd_in    (fwd_s1),
		.ramp_step (cfg.ramp_step),
		.duty      (right_duty),
		.duty_next (right_next),
		.dir_fwd   (right_dir_fwd)
	);

	// Hold the result valid until taken; raise it for each advanced request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			moving_q    <= 1'b0;
		end else begin
			moving_q <= (left_next != '0) || (right_next != '0);
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign moving    = moving_q;

endmodule

FILE: rtl/core/dspr_checker.sv
module dspr_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dspr_pkg::ADDR_W-1:0]       paddr,
	input  logic [dspr_pkg::DATA_W-1:0]       pwdata,
	input  logic [dspr_pkg::DATA_W-1:0]       prdata,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [dspr_pkg::DUTY_W-1:0]       left_duty,
	input  logic [dspr_pkg::DUTY_W-1:0]       right_duty,
	input  logic                              moving
);

	// moving flag agrees with the duties shown
	a_moving: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (moving == ((left_duty != '0) || (right_duty != '0))))
		else $error("moving flag disagrees with duties");

	// a stalled result keeps its duties
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_duty) && $stable(right_duty))
		else $error("stalled result changed");

	// ramp_step reads back what was written
	a_step_rb: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && !paddr[dspr_pkg::ADDR_W-1]
		|=> !paddr[dspr_pkg::ADDR_W-1] |-> prdata[dspr_pkg::STEP_W-1:0]
			== $past(pwdata[dspr_pkg::STEP_W-1:0]))
		else $error("ramp_step readback mismatch");

	// register bits 31..16 read as zero
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[dspr_pkg::DATA_W-1:dspr_pkg::INTERVAL_W] == '0)
		else $error("upper register bits not zero");

endmodule

bind dual_side_pwm_ramp_driver dspr_checker u_dspr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.psel       (psel),
	.penable    (penable),
	.pwrite     (pwrite),
	.paddr      (paddr),
	.pwdata     (pwdata),
	.prdata     (prdata),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.left_duty  (left_duty),
	.right_duty (right_duty),
	.moving     (moving)
);
